@@ design/hrcd_pkg.sv @@
// Package with the payload types and byte constants of the HTTP request completion detector.
package hrcd_pkg;

	// Payload of one input transfer.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
	} req_t;

	// Payload of one result transfer.
	typedef struct packed {
		logic request_ready;
		logic bad_length;
	} res_t;

	// Length of the header keyword and width of its match counter.
	localparam int unsigned KEYWORD_LEN = 15;
	localparam int unsigned KW_IDX_W    = 4;

	// Bytes of interest in the header text.
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// Progress codes while matching CR LF CR LF.
	localparam logic [1:0] TERM_NONE    = 2'd0;
	localparam logic [1:0] TERM_CR      = 2'd1;
	localparam logic [1:0] TERM_CRLF    = 2'd2;
	localparam logic [1:0] TERM_CRLFCR  = 2'd3;

	// Returns the keyword character at a given position of "Content-Length:".
	function automatic logic [7:0] keyword_char(input logic [KW_IDX_W-1:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0:    ch = 8'h43; // C
			4'd1:    ch = 8'h6F; // o
			4'd2:    ch = 8'h6E; // n
			4'd3:    ch = 8'h74; // t
			4'd4:    ch = 8'h65; // e
			4'd5:    ch = 8'h6E; // n
			4'd6:    ch = 8'h74; // t
			4'd7:    ch = 8'h2D; // -
			4'd8:    ch = 8'h4C; // L
			4'd9:    ch = 8'h65; // e
			4'd10:   ch = 8'h6E; // n
			4'd11:   ch = 8'h67; // g
			4'd12:   ch = 8'h74; // t
			4'd13:   ch = 8'h68; // h
			4'd14:   ch = 8'h3A; // :
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

@@ design/hrcd_stream_if.sv @@
// Valid/ready stream interface that carries one payload per transfer.
interface hrcd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ design/http_request_completion_detector_unit.sv @@
// Top level of the HTTP request completion detector: parser, body counter and result register.
//
//  Channel | Direction | Payload                        | Handshake
//  --------+-----------+--------------------------------+-----------
//  req     | in        | data_byte[7:0], first_byte     | valid/ready
//  res     | out       | request_ready, bad_length      | valid/ready
//
// One byte is taken per cycle unless res stalls; its result is on res in the next cycle.
// The parse state and the result register are written in the same cycle that a byte is taken.
// The input stays ready while the result register is empty or is being emptied in that cycle.
// A stall on res holds the result and blocks further input transfers until it is taken.
// arst_n clears all parse state and empties the result register.
module http_request_completion_detector_unit #(
	parameter int unsigned LENGTH_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	hrcd_stream_if.sink   req,
	hrcd_stream_if.source res
);

	typedef enum logic [1:0] {
		PH_KEYWORD,
		PH_BLANKS,
		PH_DIGITS,
		PH_SETTLED
	} phase_t;

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
	localparam int unsigned            ACC_W   = LENGTH_BITS + 4;

	// Parse state.
	logic [1:0]                       term_q;
	logic [hrcd_pkg::KW_IDX_W-1:0]    kw_q;
	phase_t                           phase_q;
	logic [LENGTH_BITS-1:0]           decl_len_q;
	logic                             len_present_q;
	logic                             len_invalid_q;
	logic                             hdr_done_q;
	logic [LENGTH_BITS-1:0]           body_cnt_q;

	// Result register.
	logic                             res_valid_q;
	hrcd_pkg::res_t                   res_q;

	// Next-state values.
	logic [1:0]                       term_d;
	logic [hrcd_pkg::KW_IDX_W-1:0]    kw_d;
	phase_t                           phase_d;
	logic [LENGTH_BITS-1:0]           decl_len_d;
	logic                             len_present_d;
	logic                             len_invalid_d;
	logic                             hdr_done_d;
	logic [LENGTH_BITS-1:0]           body_cnt_d;

	logic                             take;
	logic [7:0]                       byte_in;
	logic                             is_digit;
	logic                             is_blank;
	logic [ACC_W-1:0]                 acc_next;
	logic [hrcd_pkg::KW_IDX_W:0]      kw_adv;
	hrcd_pkg::res_t                   res_d;

	assign take      = req.valid && req.ready;
	assign req.ready = !res_valid_q || res.ready;
	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	assign byte_in  = req.data.data_byte;
	assign is_digit = (byte_in >= hrcd_pkg::CHAR_ZERO) && (byte_in <= hrcd_pkg::CHAR_NINE);
	assign is_blank = (byte_in == hrcd_pkg::CHAR_SPACE) || (byte_in == hrcd_pkg::CHAR_TAB);

	// Parse step for one byte, starting from cleared state when the byte opens a request.
	always_comb begin
		term_d        = term_q;
		kw_d          = kw_q;
		phase_d       = phase_q;
		decl_len_d    = decl_len_q;
		len_present_d = len_present_q;
		len_invalid_d = len_invalid_q;
		hdr_done_d    = hdr_done_q;
		body_cnt_d    = body_cnt_q;
		kw_adv        = '0;
		acc_next      = '0;

		if (req.data.first_byte) begin
			term_d        = hrcd_pkg::TERM_NONE;
			kw_d          = '0;
			phase_d       = PH_KEYWORD;
			decl_len_d    = '0;
			len_present_d = 1'b0;
			len_invalid_d = 1'b0;
			hdr_done_d    = 1'b0;
			body_cnt_d    = '0;
		end

		// Candidate value after one more decimal digit: ten times the value plus the digit.
		acc_next = {1'b0, decl_len_d, 3'b000} + {3'b000, decl_len_d, 1'b0}
			+ ACC_W'(byte_in - hrcd_pkg::CHAR_ZERO);

		if (hdr_done_d) begin
			// Body byte: count it, saturating at the top of the counter.
			if (body_cnt_d != LEN_MAX) begin
				body_cnt_d = body_cnt_d + 1'b1;
			end
		end else begin
			case (phase_d)
				PH_KEYWORD: begin
					if ((32'(kw_d) < hrcd_pkg::KEYWORD_LEN)
						&& (byte_in == hrcd_pkg::keyword_char(kw_d))) begin
						kw_adv = {1'b0, kw_d} + 1'b1;
					end else if (byte_in == hrcd_pkg::keyword_char('0)) begin
						kw_adv = (hrcd_pkg::KW_IDX_W+1)'(1);
					end else begin
						kw_adv = '0;
					end
					if (32'(kw_adv) >= hrcd_pkg::KEYWORD_LEN) begin
						kw_d          = '0;
						len_present_d = 1'b1;
						phase_d       = PH_BLANKS;
					end else begin
						kw_d = kw_adv[hrcd_pkg::KW_IDX_W-1:0];
					end
				end
				PH_BLANKS, PH_DIGITS: begin
					if ((phase_d == PH_BLANKS) && is_blank) begin
						phase_d = PH_BLANKS;
					end else if (!is_digit) begin
						// A value with no digits at all is invalid; otherwise it just ends.
						if (phase_d == PH_BLANKS) begin
							len_invalid_d = 1'b1;
						end
						phase_d = PH_SETTLED;
					end else if (acc_next[ACC_W-1 -: 4] != 4'd0) begin
						len_invalid_d = 1'b1;
						phase_d       = PH_SETTLED;
					end else begin
						decl_len_d = acc_next[LENGTH_BITS-1:0];
						phase_d    = PH_DIGITS;
					end
				end
				default: begin
					phase_d = phase_d;
				end
			endcase

			// Blank line detection.
			if (byte_in == hrcd_pkg::CHAR_CR) begin
				term_d = (term_d == hrcd_pkg::TERM_CRLF) ? hrcd_pkg::TERM_CRLFCR
					: hrcd_pkg::TERM_CR;
			end else if (byte_in == hrcd_pkg::CHAR_LF) begin
				if (term_d == hrcd_pkg::TERM_CR) begin
					term_d = hrcd_pkg::TERM_CRLF;
				end else if (term_d == hrcd_pkg::TERM_CRLFCR) begin
					hdr_done_d = 1'b1;
					term_d     = hrcd_pkg::TERM_NONE;
				end else begin
					term_d = hrcd_pkg::TERM_NONE;
				end
			end else begin
				term_d = hrcd_pkg::TERM_NONE;
			end
		end

		res_d.request_ready = hdr_done_d
			&& (!len_present_d || len_invalid_d || (body_cnt_d >= decl_len_d));
		res_d.bad_length    = len_invalid_d;
	end

	// Parse state and result flag load per transfer; the flag clears once res is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q        <= hrcd_pkg::TERM_NONE;
			kw_q          <= '0;
			phase_q       <= PH_KEYWORD;
			decl_len_q    <= '0;
			len_present_q <= 1'b0;
			len_invalid_q <= 1'b0;
			hdr_done_q    <= 1'b0;
			body_cnt_q    <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			if (take) begin
				term_q        <= term_d;
				kw_q          <= kw_d;
				phase_q       <= phase_d;
				decl_len_q    <= decl_len_d;
				len_present_q <= len_present_d;
				len_invalid_q <= len_invalid_d;
				hdr_done_q    <= hdr_done_d;
				body_cnt_q    <= body_cnt_d;
				res_valid_q   <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result payload needs no reset.
	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_d;
		end
	end

	// Once the headers are done the blank-line matcher is left idle.
	a_term_idle_after_headers: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_done_q |-> (term_q == hrcd_pkg::TERM_NONE))
		else $error("terminator progress active after end of headers");

	// Leaving the keyword phase requires the keyword to have been seen.
	a_phase_needs_keyword: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_KEYWORD) |-> len_present_q)
		else $error("value phase entered without keyword");

	// An invalid length can only come from a length header.
	a_invalid_needs_present: assert property (@(posedge clk) disable iff (!arst_n)
		len_invalid_q |-> len_present_q)
		else $error("length invalid without length header");

	// The keyword matcher never rests on a full match.
	a_kw_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(kw_q) < hrcd_pkg::KEYWORD_LEN)
		else $error("keyword progress out of range");

	// Input is refused only while a result waits and is not being taken.
	a_ready_blocked_by_result: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (res.valid && !res.ready))
		else $error("input stalled without a pending result");

endmodule
